@@ sv/current_surge_fault_detector_core_macros.svh @@
// assertion helpers used by the detector core rtl
`ifndef CURRENT_SURGE_FAULT_DETECTOR_CORE_MACROS_SVH
`define CURRENT_SURGE_FAULT_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during rst
`define CSFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during rst
`define CSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/csfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package csfd_pkg;

  localparam int SAMPLE_WIDTH      = 16;
  localparam int RECORDS_PER_PHASE = 3;
  localparam int MAX_RECORD_LEN    = 4096;

  localparam int PCT_W   = 10;
  localparam int LIMIT_W = 13;
  localparam int COUNT_W = 12;
  localparam int POS_W   = 2;
  localparam int FSET_W  = 3;
  localparam int NUM_PHASES = 3;

  // product width for the percentage test: sample times (100 + pct)
  localparam int PROD_W = SAMPLE_WIDTH + PCT_W + 2;
  localparam int SURGE_SCALE = 100;

  localparam int COUNT_CAP_INT = ((MAX_RECORD_LEN - 1) < 4095) ? (MAX_RECORD_LEN - 1) : 4095;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

  localparam logic [PCT_W-1:0]   PCT_RESET   = PCT_W'(10);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

  // phase codes
  localparam logic [POS_W-1:0] PH_A = 2'd0;
  localparam logic [POS_W-1:0] PH_B = 2'd1;
  localparam logic [POS_W-1:0] PH_C = 2'd2;

  // register indexes on the apb port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_RISE_PCT_A   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RISE_PCT_B   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RISE_PCT_C   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RISE_LIMIT_A = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RISE_LIMIT_B = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RISE_LIMIT_C = 3'd5;
  localparam int ADDR_W = REG_IDX_W + 2;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last_in_record;
  } csfd_in_t;

  typedef struct packed {
    logic [POS_W-1:0]               phase_index;
    logic [POS_W-1:0]               record_index;
    logic [COUNT_W-1:0]             surge_count;
    logic signed [SAMPLE_WIDTH-1:0] record_peak;
    logic                           record_fault;
    logic                           phase_done;
    logic                           phase_fault;
    logic signed [SAMPLE_WIDTH-1:0] phase_min_peak;
    logic                           verdict_valid;
    logic [FSET_W-1:0]              fault_set;
  } csfd_out_t;

  typedef struct packed {
    logic [NUM_PHASES-1:0][PCT_W-1:0]   rise_pct;
    logic [NUM_PHASES-1:0][LIMIT_W-1:0] rise_limit;
  } csfd_cfg_t;

endpackage

`default_nettype wire

@@ sv/current_surge_fault_detector_core.sv @@
// current surge fault detector. one sample transaction is accepted per clock cycle,
// sustained, whatever the record lengths, while the result side keeps up. an accepted
// sample lands in an input register, and when it moves on the record logic (one percentage
// compare built from two short multipliers, the saturating surge counter and the
// peak/minimum updates) folds it into the record state; a sample flagged last_in_record
// then loads the result register, from which its result transaction is offered. sample_ready
// drops only while the staged sample closes a record and the previous result is still
// waiting; the result register frees in the same cycle it is taken, so a consumer that keeps
// result_ready high never slows the stream. there is no clearing pass after reset. records
// run three per phase, phases a, b, c, then the round restarts at phase a. thresholds and
// limits are written over the apb port at byte addresses 0x00 to 0x14 and should only be
// changed while no record is open.
`timescale 1ns / 1ps
`default_nettype none
`include "current_surge_fault_detector_core_macros.svh"

module current_surge_fault_detector_core import csfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // sample transactions
  input  logic              sample_valid,
  output logic              sample_ready,
  input  csfd_in_t          sample_data,
  // result transactions
  output logic              result_valid,
  input  logic              result_ready,
  output csfd_out_t         result_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  csfd_cfg_t             cfg;
  logic                  cfg_wr;
  logic [REG_IDX_W-1:0]  reg_idx;

  // input register
  logic                  stage_valid;
  csfd_in_t              stage;
  logic                  advance;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // configuration registers, write at the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rise_pct   <= {NUM_PHASES{PCT_RESET}};
      cfg.rise_limit <= {NUM_PHASES{LIMIT_RESET}};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_RISE_PCT_A:   cfg.rise_pct[0]   <= pwdata[PCT_W-1:0];
        REG_RISE_PCT_B:   cfg.rise_pct[1]   <= pwdata[PCT_W-1:0];
        REG_RISE_PCT_C:   cfg.rise_pct[2]   <= pwdata[PCT_W-1:0];
        REG_RISE_LIMIT_A: cfg.rise_limit[0] <= pwdata[LIMIT_W-1:0];
        REG_RISE_LIMIT_B: cfg.rise_limit[1] <= pwdata[LIMIT_W-1:0];
        REG_RISE_LIMIT_C: cfg.rise_limit[2] <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_RISE_PCT_A:   prdata = 32'(cfg.rise_pct[0]);
      REG_RISE_PCT_B:   prdata = 32'(cfg.rise_pct[1]);
      REG_RISE_PCT_C:   prdata = 32'(cfg.rise_pct[2]);
      REG_RISE_LIMIT_A: prdata = 32'(cfg.rise_limit[0]);
      REG_RISE_LIMIT_B: prdata = 32'(cfg.rise_limit[1]);
      REG_RISE_LIMIT_C: prdata = 32'(cfg.rise_limit[2]);
      default:          prdata = '0;
    endcase
  end

  // the staged sample moves on unless it closes a record and the result slot is still held
  assign advance      = stage_valid && (!stage.last_in_record || !result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      stage <= sample_data;
    end
  end

  csfd_record u_record (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .stage        (stage),
    .cfg          (cfg),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result_data  (result_data)
  );

  // a verdict only comes with the closing record of phase c
  `CSFD_ASSERT_NOW(a_verdict_phase_c, result_valid && result_data.verdict_valid, result_data.phase_done && result_data.phase_index == PH_C, "verdict outside the end of phase c")

  // a blocked staged sample is kept
  `CSFD_ASSERT_NEXT(a_stage_held, stage_valid && !advance, stage_valid && $stable(stage), "staged sample lost while blocked")

  // a new result only follows a record-closing sample
  `CSFD_ASSERT_NOW(a_result_source, $rose(result_valid), $past(advance && stage.last_in_record), "result raised without a closing sample")

  // threshold write for phase a lands as written
  `CSFD_ASSERT_NEXT(a_cfg_write, cfg_wr && reg_idx == REG_RISE_PCT_A, cfg.rise_pct[0] == $past(pwdata[PCT_W-1:0]), "phase a threshold write lost")

endmodule

`default_nettype wire

@@ sv/csfd_surge_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// surge test: sample*100 > previous*(100+pct), exact signed arithmetic
module csfd_surge_cmp import csfd_pkg::*; (
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic signed [SAMPLE_WIDTH-1:0] previous,
  input  logic [PCT_W-1:0]               rise_pct,
  output logic                           surge
);

  logic [PCT_W:0]             factor;
  logic signed [PROD_W-1:0]   lhs;
  logic signed [PROD_W-1:0]   rhs;

  assign factor = (PCT_W+1)'(SURGE_SCALE) + {1'b0, rise_pct};
  assign lhs    = PROD_W'(sample) * PROD_W'(SURGE_SCALE);
  assign rhs    = PROD_W'(previous) * $signed(PROD_W'(factor));
  assign surge  = lhs > rhs;

endmodule

`default_nettype wire

@@ sv/csfd_record.sv @@
`timescale 1ns / 1ps
`default_nettype none

// per-record tracking, phase summary and the result register
module csfd_record import csfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  csfd_in_t  stage,
  input  csfd_cfg_t cfg,
  input  logic      result_ready,
  output logic      result_valid,
  output csfd_out_t result_data
);

  logic signed [SAMPLE_WIDTH-1:0] previous_sample, previous_sample_next;
  logic                           record_started, record_started_next;
  logic [COUNT_W-1:0]             surge_counter, surge_counter_next;
  logic signed [SAMPLE_WIDTH-1:0] peak_value, peak_value_next;
  logic [POS_W-1:0]               record_position, record_position_next;
  logic [POS_W-1:0]               phase_position, phase_position_next;
  logic                           phase_any_fault, phase_any_fault_next;
  logic signed [SAMPLE_WIDTH-1:0] phase_lowest_peak, phase_lowest_peak_next;
  logic [FSET_W-1:0]              faulty_phases, faulty_phases_next;

  logic [POS_W-1:0]               ph;
  logic                           surge;
  logic                           rec_fault;
  logic                           any_fault_upd;
  logic signed [SAMPLE_WIDTH-1:0] lowest_upd;
  logic                           done;
  logic                           verdict;
  logic [FSET_W-1:0]              faulty_upd;
  csfd_out_t                      result_next;

  assign ph = (phase_position > PH_C) ? PH_C : phase_position;

  csfd_surge_cmp u_cmp (
    .sample   (stage.sample),
    .previous (previous_sample),
    .rise_pct (cfg.rise_pct[ph]),
    .surge    (surge)
  );

  always_comb begin
    previous_sample_next   = previous_sample;
    record_started_next    = record_started;
    surge_counter_next     = surge_counter;
    peak_value_next        = peak_value;
    record_position_next   = record_position;
    phase_position_next    = phase_position;
    phase_any_fault_next   = phase_any_fault;
    phase_lowest_peak_next = phase_lowest_peak;
    faulty_phases_next     = faulty_phases;

    // record accumulation
    if (!record_started) begin
      peak_value_next    = stage.sample;
      surge_counter_next = '0;
    end else begin
      if (surge && surge_counter < COUNT_CAP) begin
        surge_counter_next = surge_counter + COUNT_W'(1);
      end
      if (stage.sample > peak_value) begin
        peak_value_next = stage.sample;
      end
    end

    rec_fault = {1'b0, surge_counter_next} >= cfg.rise_limit[ph];
    lowest_upd = (record_position == '0 || peak_value_next < phase_lowest_peak) ?
                 peak_value_next : phase_lowest_peak;
    any_fault_upd = ((record_position == '0) ? 1'b0 : phase_any_fault) | rec_fault;
    done = ({1'b0, record_position} + 3'd1) >= 3'(RECORDS_PER_PHASE);
    verdict = done && (ph == PH_C);
    faulty_upd = faulty_phases;
    if (done && any_fault_upd) begin
      faulty_upd = faulty_phases | (FSET_W'(1) << ph);
    end

    result_next.phase_index    = ph;
    result_next.record_index   = record_position;
    result_next.surge_count    = surge_counter_next;
    result_next.record_peak    = peak_value_next;
    result_next.record_fault   = rec_fault;
    result_next.phase_done     = done;
    result_next.phase_fault    = done && any_fault_upd;
    result_next.phase_min_peak = done ? lowest_upd : '0;
    result_next.verdict_valid  = verdict;
    result_next.fault_set      = verdict ? faulty_upd : '0;

    if (advance) begin
      previous_sample_next = stage.sample;
      if (!stage.last_in_record) begin
        record_started_next = 1'b1;
      end else begin
        record_started_next    = 1'b0;
        phase_lowest_peak_next = lowest_upd;
        faulty_phases_next     = faulty_upd;
        if (done) begin
          record_position_next = '0;
          phase_any_fault_next = 1'b0;
          if (ph == PH_C) begin
            phase_position_next = PH_A;
            faulty_phases_next  = '0;
          end else begin
            phase_position_next = ph + POS_W'(1);
          end
        end else begin
          record_position_next = record_position + POS_W'(1);
          phase_any_fault_next = any_fault_upd;
        end
      end
    end else begin
      surge_counter_next = surge_counter;
      peak_value_next    = peak_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample   <= '0;
      record_started    <= 1'b0;
      surge_counter     <= '0;
      peak_value        <= '0;
      record_position   <= '0;
      phase_position    <= PH_A;
      phase_any_fault   <= 1'b0;
      phase_lowest_peak <= '0;
      faulty_phases     <= '0;
      result_valid      <= 1'b0;
    end else begin
      previous_sample   <= previous_sample_next;
      record_started    <= record_started_next;
      surge_counter     <= surge_counter_next;
      peak_value        <= peak_value_next;
      record_position   <= record_position_next;
      phase_position    <= phase_position_next;
      phase_any_fault   <= phase_any_fault_next;
      phase_lowest_peak <= phase_lowest_peak_next;
      faulty_phases     <= faulty_phases_next;
      if (advance && stage.last_in_record) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last_in_record) begin
      result_data <= result_next;
    end
  end

endmodule

`default_nettype wire
